// File: rtl/sktil_pkg.sv
// ----------------------------------------------------------------------------
// sktil_pkg
// Shared widths and codes for the sorted key table.
// ----------------------------------------------------------------------------
package sktil_pkg;

  localparam int KEY_W = 8;
  localparam int HND_W = 16;
  localparam int POS_W = 6;
  localparam int ST_W  = 2;

  // request action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

endpackage

// File: rtl/sorted_key_table_insert_lookup.sv
// ----------------------------------------------------------------------------
// sorted_key_table_insert_lookup
// Table of key/handle entries kept in ascending key order; insert and
// binary-search lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one request: in_action selects
//   insert (place in_key/in_handle before the first stored key not smaller
//   than in_key) or lookup (binary search for in_key).
//   Result channel (out_valid/out_stall) returns one result per request:
//   status, handle of the found entry and the position inserted or found.
// Work per request, from acceptance to out_valid:
//   insert : from the top, one memory read, then the compare and write-back
//            per moved entry, the last compare writing the new entry; when
//            the new entry lands in slot 0 the final compare is skipped
//   full   : straight to the result, with no table access
//   lookup : at most floor(log2(TABLE_DEPTH))+1 probes, each one read plus
//            a compare; a miss ends when the search window is empty
// in_stall drops on the edge that raises out_valid, so a new request is taken
// only once the last result has left for the output register, which can stall.
// Reset clears the state, the entry count and out_valid; the key and handle
// memories are not cleared, only entries below the count are ever read.
// A stalled result holds in the output register; the finished result of
// the next request waits internally until the output register frees up.
// ----------------------------------------------------------------------------
module sorted_key_table_insert_lookup #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic [sktil_pkg::KEY_W-1:0]  in_key,
  input  logic [sktil_pkg::HND_W-1:0]  in_handle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sktil_pkg::ST_W-1:0]   out_status,
  output logic [sktil_pkg::HND_W-1:0]  out_result_handle,
  output logic [sktil_pkg::POS_W-1:0]  out_position
);

  import sktil_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS_RD = 3'd1;
  localparam logic [2:0] S_INS_WR = 3'd2;
  localparam logic [2:0] S_LK_RD  = 3'd3;
  localparam logic [2:0] S_LK_CMP = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  // entry memories, one write and one registered read port each
  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [HND_W-1:0] hnd_mem [TABLE_DEPTH];

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;       // stored entries
  logic [CW-1:0]    idx_r, idx_nxt;       // insert: slot being filled
  logic [CW-1:0]    lo_r, lo_nxt;         // search window [lo, hp1)
  logic [CW-1:0]    hp1_r, hp1_nxt;
  logic [AW-1:0]    mid_r, mid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [HND_W-1:0] hnd_r, hnd_nxt;
  logic [ST_W-1:0]  res_st_r, res_st_nxt;
  logic [HND_W-1:0] res_hnd_r, res_hnd_nxt;
  logic [POS_W-1:0] res_pos_r, res_pos_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]  out_status_r, out_status_nxt;
  logic [HND_W-1:0] out_hnd_r, out_hnd_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;

  logic [KEY_W-1:0] rd_key_r;
  logic [HND_W-1:0] rd_hnd_r;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_key;
  logic [HND_W-1:0] wr_hnd;

  logic [CW:0]      mid_sum;
  logic [CW-1:0]    mid_w;

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_handle = out_hnd_r;
  assign out_position      = out_pos_r;

  // floor((lo + hi) / 2) with hi = hp1 - 1; only used while lo < hp1
  assign mid_sum = {1'b0, lo_r} + {1'b0, hp1_r} - {{CW{1'b0}}, 1'b1};
  assign mid_w   = mid_sum[CW:1];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    lo_nxt        = lo_r;
    hp1_nxt       = hp1_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    hnd_nxt       = hnd_r;
    res_st_nxt    = res_st_r;
    res_hnd_nxt   = res_hnd_r;
    res_pos_nxt   = res_pos_r;
    out_valid_nxt = out_valid_r;
    out_status_nxt = out_status_r;
    out_hnd_nxt   = out_hnd_r;
    out_pos_nxt   = out_pos_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_key        = key_r;
    wr_hnd        = hnd_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt = in_key;
          hnd_nxt = in_handle;
          if (in_action == ACT_INSERT) begin
            if (cnt_r == CW'(TABLE_DEPTH)) begin
              res_st_nxt  = ST_FULL;
              res_hnd_nxt = '0;
              res_pos_nxt = '0;
              state_nxt   = S_FIN;
            end else begin
              idx_nxt   = cnt_r;
              state_nxt = S_INS_RD;
            end
          end else begin
            lo_nxt    = '0;
            hp1_nxt   = cnt_r;
            state_nxt = S_LK_RD;
          end
        end
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          // every stored key moved up: new entry goes to the front
          wr_en       = 1'b1;
          wr_addr     = '0;
          res_st_nxt  = ST_OK;
          res_hnd_nxt = '0;
          res_pos_nxt = '0;
          cnt_nxt     = cnt_r + CW'(1);
          state_nxt   = S_FIN;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(idx_r - CW'(1));
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx_r);
        if (rd_key_r >= key_r) begin
          wr_key    = rd_key_r;
          wr_hnd    = rd_hnd_r;
          idx_nxt   = idx_r - CW'(1);
          state_nxt = S_INS_RD;
        end else begin
          res_st_nxt  = ST_OK;
          res_hnd_nxt = '0;
          res_pos_nxt = POS_W'(idx_r);
          cnt_nxt     = cnt_r + CW'(1);
          state_nxt   = S_FIN;
        end
      end
      S_LK_RD: begin
        if (lo_r < hp1_r) begin
          rd_en     = 1'b1;
          rd_addr   = AW'(mid_w);
          mid_nxt   = AW'(mid_w);
          state_nxt = S_LK_CMP;
        end else begin
          res_st_nxt  = ST_NOT_FOUND;
          res_hnd_nxt = '0;
          res_pos_nxt = '0;
          state_nxt   = S_FIN;
        end
      end
      S_LK_CMP: begin
        if (rd_key_r < key_r) begin
          lo_nxt    = CW'(mid_r) + CW'(1);
          state_nxt = S_LK_RD;
        end else if (rd_key_r > key_r) begin
          hp1_nxt   = CW'(mid_r);
          state_nxt = S_LK_RD;
        end else begin
          res_st_nxt  = ST_OK;
          res_hnd_nxt = rd_hnd_r;
          res_pos_nxt = POS_W'(mid_r);
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_st_r;
          out_hnd_nxt    = res_hnd_r;
          out_pos_nxt    = res_pos_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    lo_r         <= lo_nxt;
    hp1_r        <= hp1_nxt;
    mid_r        <= mid_nxt;
    key_r        <= key_nxt;
    hnd_r        <= hnd_nxt;
    res_st_r     <= res_st_nxt;
    res_hnd_r    <= res_hnd_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_hnd_r    <= out_hnd_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  // memories: a read and a write never happen in one cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      hnd_mem[wr_addr] <= wr_hnd;
    end
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_hnd_r <= hnd_mem[rd_addr];
    end
  end

  // table never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // count only grows, one entry at a time
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("entry count changed by other than one");

  // a miss or full result carries no handle and no position
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |->
      (out_hnd_r == '0 && out_pos_r == '0))
    else $error("non-ok result with handle or position");

  // an accepted request always starts work
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("request accepted without starting work");

endmodule

// File: dv/sktil_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sktil_table_checker
// Tracks the sorted key table from the request stream and compares each
// answer on the result channel against the predicted one, in order.
// ----------------------------------------------------------------------------
module sktil_table_checker #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_action,
  input  logic [sktil_pkg::KEY_W-1:0] in_key,
  input  logic [sktil_pkg::HND_W-1:0] in_handle,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [sktil_pkg::ST_W-1:0]  out_status,
  input  logic [sktil_pkg::HND_W-1:0] out_result_handle,
  input  logic [sktil_pkg::POS_W-1:0] out_position,
  output int                          fail_count,
  output int                          pending
);

  import sktil_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [HND_W-1:0] hnd;
    logic [POS_W-1:0] pos;
  } table_answer_t;

  logic [KEY_W-1:0] key_tab [TABLE_DEPTH];
  logic [HND_W-1:0] hnd_tab [TABLE_DEPTH];
  int               fill;
  table_answer_t    answers_due [$];

  // Applies one request to the shadow table and returns its answer.
  function automatic table_answer_t apply_request(input logic act,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic [HND_W-1:0] h);
    table_answer_t ans;
    int slot;
    int lo;
    int hi;
    int mid;
    ans = '{status: ST_NOT_FOUND, hnd: '0, pos: '0};
    if (act == ACT_INSERT) begin
      if (fill >= TABLE_DEPTH) begin
        ans.status = ST_FULL;
      end else begin
        // new entry lands in front of the first key not smaller than it
        slot = 0;
        while (slot < fill && k > key_tab[slot]) slot++;
        for (int i = fill; i > slot; i--) begin
          key_tab[i] = key_tab[i-1];
          hnd_tab[i] = hnd_tab[i-1];
        end
        key_tab[slot] = k;
        hnd_tab[slot] = h;
        fill++;
        ans.status = ST_OK;
        ans.pos    = POS_W'(slot);
      end
    end else begin
      lo = 0;
      hi = fill - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (key_tab[mid] < k) begin
          lo = mid + 1;
        end else if (key_tab[mid] > k) begin
          hi = mid - 1;
        end else begin
          ans.status = ST_OK;
          ans.hnd    = hnd_tab[mid];
          ans.pos    = POS_W'(mid);
          return ans;
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    table_answer_t due;
    if (!rst_n) begin
      fill = 0;
      answers_due.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $error("result with no request outstanding: status %0d handle %0h pos %0d",
                 out_status, out_result_handle, out_position);
          fail_count++;
        end else begin
          due = answers_due.pop_front();
          if (out_status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, out_status);
            fail_count++;
          end
          if (out_result_handle !== due.hnd) begin
            $error("result_handle: expected %0h, got %0h", due.hnd, out_result_handle);
            fail_count++;
          end
          if (out_position !== due.pos) begin
            $error("position: expected %0d, got %0d", due.pos, out_position);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        answers_due.push_back(apply_request(in_action, in_key, in_handle));
    end
    pending = answers_due.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top level for the sorted key table: drives insert and lookup requests
// with random gaps and result stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
  import sktil_pkg::*;

  localparam int TABLE_DEPTH  = 32;
  localparam int RANDOM_ITEMS = 1330;
  localparam int WATCHDOG_MAX = 3000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES = 100;   // longer than the worst insert shift

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_action;
  logic [KEY_W-1:0] in_key;
  logic [HND_W-1:0] in_handle;
  logic             out_valid;
  logic             out_stall;
  logic [ST_W-1:0]  out_status;
  logic [HND_W-1:0] out_result_handle;
  logic [POS_W-1:0] out_position;

  int fail_count;
  int pending;

  // upper bound for gaps and stalls; changed in stretches, 0 means no idling
  int idle_max;

  // keys the table should hold, used only to aim lookups and duplicates
  logic [KEY_W-1:0] stored_keys [$];
  int n_insert;
  int n_overflow;
  int n_lookup;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  sorted_key_table_insert_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_key           (in_key),
    .in_handle        (in_handle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_handle(out_result_handle),
    .out_position     (out_position)
  );

  sktil_table_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_key           (in_key),
    .in_handle        (in_handle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_result_handle(out_result_handle),
    .out_position     (out_position),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // One request: optional gap with valid low, then hold until accepted.
  // Valid stays high across back-to-back requests (no drop and re-raise).
  task automatic send_request(input logic act, input logic [KEY_W-1:0] k,
                              input logic [HND_W-1:0] h);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_key    <= k;
    in_handle <= h;
    do @(posedge clk); while (!in_fire);
    @(negedge clk);
  endtask

  task automatic send_insert(input logic [KEY_W-1:0] k, input logic [HND_W-1:0] h);
    n_insert++;
    if (stored_keys.size() < TABLE_DEPTH)
      stored_keys.push_back(k);
    else
      n_overflow++;
    send_request(ACT_INSERT, k, h);
  endtask

  task automatic send_lookup(input logic [KEY_W-1:0] k);
    n_lookup++;
    send_request(ACT_LOOKUP, k, HND_W'($urandom()));
  endtask

  // Hold the sender until every outstanding request has answered.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] some_stored_key();
    if (stored_keys.size() == 0) return KEY_W'($urandom());
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  // Result side: a fresh stall length for every result.
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = $urandom_range(0, idle_max);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_fire);
      @(negedge clk);
    end
  end

  // Watchdog: any long stretch without a handshake ends the run.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_MAX) begin
      @(posedge clk);
      if (in_fire || out_fire || !rst_n) quiet = 0;
      else quiet++;
    end
    $display("sorted_key_table_insert_lookup verification failed");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0] k;
    int pick;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_action = ACT_INSERT;
    in_key    = '0;
    in_handle = '0;
    idle_max  = 3;
    n_insert  = 0;
    n_overflow = 0;
    n_lookup  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed ---
    // lookups on an empty table miss
    send_lookup(8'h00);
    send_lookup(8'hFF);
    send_insert(8'h80, 16'h1234);
    send_lookup(8'h80);
    // key and handle extremes
    send_insert(8'h00, 16'h0000);
    send_insert(8'hFF, 16'hFFFF);
    // duplicates go in front of the equal keys already stored
    send_insert(8'h80, 16'hAAAA);
    send_insert(8'h80, 16'h5555);
    send_lookup(8'h00);
    send_lookup(8'hFF);
    send_lookup(8'h80);
    // near misses on both sides of a stored key
    send_lookup(8'h7F);
    send_lookup(8'h81);
    send_insert(8'h01, 16'h8001);
    send_insert(8'hFE, 16'h7FFE);
    send_lookup(8'h01);
    send_lookup(8'hFE);
    send_lookup(8'h02);
    send_insert(8'h80, 16'h0F0F);
    send_lookup(8'h80);

    // --- random ---
    // Early on inserts are frequent so the table fills and then overflows;
    // most lookups aim at stored keys or their neighbors.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_max = 0;
          1: idle_max = 4;
          default: idle_max = 14;
        endcase
      end
      if (n % 250 == 0) drain_results();
      if ($urandom_range(0, (n < 700) ? 7 : 19) == 0) begin
        pick = $urandom_range(0, 7);
        case (pick)
          0: k = 8'h00;
          1: k = 8'hFF;
          2, 3: k = some_stored_key();
          default: k = KEY_W'($urandom());
        endcase
        send_insert(k, HND_W'($urandom()));
      end else begin
        pick = $urandom_range(0, 7);
        case (pick)
          0: k = KEY_W'($urandom());
          1: k = some_stored_key() + 8'd1;
          2: k = some_stored_key() - 8'd1;
          default: k = some_stored_key();
        endcase
        send_lookup(k);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d inserts (%0d against a full table) and %0d lookups,",
             n_insert, n_overflow, n_lookup);
    $display("with request gaps and result stalls of up to 14 cycles.");
    if (fail_count == 0)
      $display("sorted_key_table_insert_lookup verification clean");
    else
      $display("sorted_key_table_insert_lookup verification failed");
    $finish;
  end

endmodule

// File: sorted_key_table_insert_lookup.f
rtl/sktil_pkg.sv
rtl/sorted_key_table_insert_lookup.sv
dv/sktil_table_checker.sv
dv/tb.sv
